// ----- hw/rtl/lcas_pkg.sv -----
package lcas_pkg;

	// Fixed field widths
	localparam int ROW_W     = 64;
	localparam int COL_W     = 7;
	localparam int NBR_CNT_W = 4;

	// Life rule: B3/S23
	localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = 4'd3;
	localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_LVL_W = 3;

	// Register port
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_GRID_WIDTH = 2'd0;
	localparam logic [COL_W-1:0]      GRID_WIDTH_RESET = 7'd64;

	typedef struct packed {
		logic [ROW_W-1:0] row_cells;
		logic             last_row;
	} row_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] next_row_cells;
		logic             frame_end;
	} res_item_t;

	typedef struct packed {
		logic [FIFO_LVL_W-1:0] level;
		logic                  room2;
	} fifo_status_t;

	// Column c is in use when c < width
	function automatic logic [ROW_W-1:0] width_mask(input logic [COL_W-1:0] w);
		logic [ROW_W-1:0] m;
		m = '0;
		for (int c = 0; c < ROW_W; c++) begin
			m[c] = (COL_W'(c) < w);
		end
		return m;
	endfunction

endpackage

// ----- hw/rtl/lcas_cell.sv -----
module lcas_cell
	import lcas_pkg::*;
(
	input  logic [2:0] up,
	input  logic [2:0] mid,
	input  logic [2:0] down,
	output logic       next_state
);

	logic [NBR_CNT_W-1:0] nbr_cnt;

	// Eight-neighbour count; bit 0 is the left column, bit 2 the right
	assign nbr_cnt = NBR_CNT_W'(up[0]) + NBR_CNT_W'(up[1]) + NBR_CNT_W'(up[2])
		+ NBR_CNT_W'(mid[0]) + NBR_CNT_W'(mid[2])
		+ NBR_CNT_W'(down[0]) + NBR_CNT_W'(down[1]) + NBR_CNT_W'(down[2]);

	// Birth on three, survival on two
	assign next_state = (nbr_cnt == BIRTH_COUNT) || ((nbr_cnt == SURVIVE_COUNT) && mid[1]);

endmodule

// ----- hw/rtl/lcas_row_gen.sv -----
module lcas_row_gen
	import lcas_pkg::*;
#(
	parameter int LANES = 64
) (
	input  logic [LANES-1:0] up_row,
	input  logic [LANES-1:0] mid_row,
	input  logic [LANES-1:0] down_row,
	input  logic [COL_W-1:0] grid_width,
	output logic [ROW_W-1:0] next_row
);

	logic [ROW_W-1:0] full_mask;
	logic [LANES-1:0] col_mask;
	logic [LANES+1:0] up_pad;
	logic [LANES+1:0] mid_pad;
	logic [LANES+1:0] down_pad;
	logic [LANES-1:0] lane_next;

	assign full_mask = width_mask(grid_width);
	assign col_mask  = full_mask[LANES-1:0];

	// Dead border on both sides; pad bit c+1 is column c
	assign up_pad   = {1'b0, up_row & col_mask, 1'b0};
	assign mid_pad  = {1'b0, mid_row & col_mask, 1'b0};
	assign down_pad = {1'b0, down_row & col_mask, 1'b0};

	// One cell per column
	for (genvar c = 0; c < LANES; c++) begin : g_lane
		lcas_cell u_cell (
			.up        (up_pad[c+2:c]),
			.mid       (mid_pad[c+2:c]),
			.down      (down_pad[c+2:c]),
			.next_state(lane_next[c])
		);
	end

	// Merge lanes, clear columns outside the grid
	assign next_row = ROW_W'(lane_next & col_mask);

endmodule

// ----- hw/rtl/lcas_res_fifo.sv -----
module lcas_res_fifo
	import lcas_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_a,
	input  res_item_t    item_a,
	input  logic         push_b,
	input  res_item_t    item_b,
	input  logic         pop,
	output logic         head_valid,
	output res_item_t    head_item,
	output fifo_status_t status
);

	res_item_t             entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] wr_ptr_nx1;
	logic [FIFO_LVL_W-1:0] level_q;
	logic [FIFO_LVL_W-1:0] n_push;
	logic                  first_push;
	logic                  second_push;
	logic                  pop_en;
	res_item_t             first_item;

	// Up to two writes per cycle, A ahead of B
	assign first_push  = push_a | push_b;
	assign second_push = push_a & push_b;
	assign first_item  = push_a ? item_a : item_b;
	assign wr_ptr_nx1  = wr_ptr_q + 1'b1;
	assign n_push      = FIFO_LVL_W'(first_push) + FIFO_LVL_W'(second_push);

	assign head_valid   = (level_q != '0);
	assign head_item    = entries_q[rd_ptr_q];
	assign pop_en       = pop & head_valid;
	assign status.level = level_q;
	assign status.room2 = (level_q <= FIFO_LVL_W'(FIFO_DEPTH - 2));

	// Entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			if (first_push && (wr_ptr_q == FIFO_PTR_W'(i))) begin
				entries_q[i] <= first_item;
			end else if (second_push && (wr_ptr_nx1 == FIFO_PTR_W'(i))) begin
				entries_q[i] <= item_b;
			end
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_push);
			if (pop_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			level_q <= level_q + n_push - FIFO_LVL_W'(pop_en);
		end
	end

endmodule

// ----- hw/rtl/life_cellular_automaton_step_unit.sv -----
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-------------------------------
// row      | row_valid / row_ready       | row_item (row_cells, last_row)
// res      | res_valid / res_ready       | res_item (next_row_cells, frame_end)
// config   | psel, penable, pwrite, ...  | grid_width at address 0
//
// A row is accepted every cycle while the four-entry result queue has two free slots.
// Each row is processed combinationally by a bank of MAX_WIDTH cell lanes (two banks,
// one for the held row and one for a bottom row); results leave the queue one per cycle
// while res_ready is high. A bottom row that follows a held row yields two transactions.
// Reset clears the held rows and sets grid_width to 64; no clearing pass.
// A stalled result side holds the queue; the row side stalls once fewer than two slots remain.
module life_cellular_automaton_step_unit
	import lcas_pkg::*;
#(
	parameter int MAX_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  row_valid,
	output logic                  row_ready,
	input  row_item_t             row_item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_item_t             res_item
);

	logic [COL_W-1:0]     grid_width_q;
	logic [MAX_WIDTH-1:0] above_q;
	logic [MAX_WIDTH-1:0] middle_q;
	logic                 middle_valid_q;
	logic [ROW_W-1:0]     full_mask;
	logic [MAX_WIDTH-1:0] col_mask;
	logic [MAX_WIDTH-1:0] row_m;
	logic [MAX_WIDTH-1:0] b_above;
	logic [ROW_W-1:0]     gen_a_row;
	logic [ROW_W-1:0]     gen_b_row;
	logic                 row_fire;
	logic                 push_a;
	logic                 push_b;
	logic                 cfg_wr;
	res_item_t            item_a;
	res_item_t            item_b;
	fifo_status_t         fifo_status;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr == REG_GRID_WIDTH);

	always_comb begin
		prdata = '0;
		if (paddr == REG_GRID_WIDTH) begin
			prdata = APB_DATA_W'(grid_width_q);
		end
	end

	// Incoming row masked to the current width
	assign full_mask = width_mask(grid_width_q);
	assign col_mask  = full_mask[MAX_WIDTH-1:0];
	assign row_m     = row_item.row_cells[MAX_WIDTH-1:0] & col_mask;
	assign row_fire  = row_valid & row_ready;

	// Held row's next generation, with the new row below
	lcas_row_gen #(.LANES(MAX_WIDTH)) u_gen_a (
		.up_row    (above_q),
		.mid_row   (middle_q),
		.down_row  (row_m),
		.grid_width(grid_width_q),
		.next_row  (gen_a_row)
	);

	// Bottom row's next generation, dead row below
	assign b_above = middle_valid_q ? middle_q : '0;

	lcas_row_gen #(.LANES(MAX_WIDTH)) u_gen_b (
		.up_row    (b_above),
		.mid_row   (row_m),
		.down_row  ('0),
		.grid_width(grid_width_q),
		.next_row  (gen_b_row)
	);

	assign push_a = row_fire & middle_valid_q;
	assign push_b = row_fire & row_item.last_row;

	assign item_a.next_row_cells = gen_a_row;
	assign item_a.frame_end      = 1'b0;
	assign item_b.next_row_cells = gen_b_row;
	assign item_b.frame_end      = 1'b1;

	// Result queue
	lcas_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.item_a    (item_a),
		.push_b    (push_b),
		.item_b    (item_b),
		.pop       (res_ready),
		.head_valid(res_valid),
		.head_item (res_item),
		.status    (fifo_status)
	);

	assign row_ready = fifo_status.room2;

	// Width register and row window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= GRID_WIDTH_RESET;
			above_q        <= '0;
			middle_q       <= '0;
			middle_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				grid_width_q <= pwdata[COL_W-1:0];
			end
			if (row_fire) begin
				if (row_item.last_row) begin
					above_q        <= '0;
					middle_q       <= '0;
					middle_valid_q <= 1'b0;
				end else begin
					above_q        <= middle_valid_q ? middle_q : '0;
					middle_q       <= row_m;
					middle_valid_q <= 1'b1;
				end
			end
		end
	end

	// A bottom row always leaves a result queued on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(row_fire && row_item.last_row) |=> res_valid)
		else $error("bottom row produced no queued result");

	// A bottom row closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(row_fire && row_item.last_row) |=> !middle_valid_q)
		else $error("row still held after bottom row");

	// Queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_status.level <= FIFO_LVL_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	// A held row plus a non-bottom row adds exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(row_fire && middle_valid_q && !row_item.last_row && !(res_valid && res_ready))
		|=> fifo_status.level == $past(fifo_status.level) + 1'b1)
		else $error("queue level did not advance by one");

endmodule
